@@ rtl/core/slru_pkg.sv @@
package slru_pkg;

  // width of the byte address carried by a lookup request
  localparam int unsigned IN_ADDR_W = 32;

  typedef logic [IN_ADDR_W-1:0] byte_addr_t;

endpackage

@@ rtl/core/slru_addr_if.sv @@
interface slru_addr_if
  import slru_pkg::*;
();
  logic       valid;
  logic       ready;
  byte_addr_t byte_address;

  modport source (output valid, output byte_address, input ready);
  modport sink   (input valid, input byte_address, output ready);
endinterface

@@ rtl/core/slru_hit_if.sv @@
interface slru_hit_if;
  logic valid;
  logic ready;
  logic is_hit;

  modport source (output valid, output is_hit, input ready);
  modport sink   (input valid, input is_hit, output ready);
endinterface

@@ rtl/core/set_assoc_lru_tag_lookup.sv @@
// Tag directory of a set-associative cache with true LRU replacement. Each
// request carries a byte address; the block answers with is_hit and updates
// the set: a hit makes the way most recent, a miss installs the tag in the
// lowest invalid way or else in the least recently used way (lowest way on a
// tie). SET_COUNT and BLOCK_BYTES are powers of two. Throughput is one
// request per clock unless the result side stalls or the clearing pass
// runs; a request moves from the lookup stage into the result register once
// that register is free or being emptied, and waits there while the next
// request is already being looked up. The set row (valid, rank and tag of
// every way) lives in one memory with a registered read, and a row written
// in the same cycle as the next read of that set is forwarded. After reset a
// clearing pass writes every row once, during which in_chan.ready is low.
module set_assoc_lru_tag_lookup
  import slru_pkg::*;
#(
  parameter int unsigned SET_COUNT   = 128,
  parameter int unsigned BLOCK_BYTES = 16,
  parameter int unsigned WAYS        = 2,
  parameter int unsigned ADDR_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  slru_addr_if.sink   in_chan,
  slru_hit_if.source  out_chan
);

  // address slicing
  localparam int unsigned OFF_BITS = $clog2(BLOCK_BYTES);
  localparam int unsigned IDX_BITS = $clog2(SET_COUNT);
  localparam int unsigned IDX_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int unsigned TAG_RAW  = IN_ADDR_W - OFF_BITS - IDX_BITS;
  localparam int unsigned TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int unsigned RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned WAY_W    = RANK_W;

  localparam byte_addr_t ADDR_MASK = (ADDR_BITS >= IN_ADDR_W) ? '1 :
                                     byte_addr_t'((64'd1 << ADDR_BITS) - 64'd1);
  localparam byte_addr_t SET_MASK  = byte_addr_t'(SET_COUNT - 1);
  localparam logic [IDX_W-1:0] LAST_SET = IDX_W'(SET_COUNT - 1);

  typedef struct packed {
    logic              vld;
    logic [RANK_W-1:0] rank;
    logic [TAG_W-1:0]  tag;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  // clearing pass
  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_cnt_r;

  // lookup stage
  logic             s1_v_r;
  logic [IDX_W-1:0] s1_set_r;
  logic [TAG_W-1:0] s1_tag_r;
  row_t             row_rd_r;
  logic             fwd_v_r;
  row_t             fwd_row_r;

  // result register
  logic out_v_r;
  logic out_hit_r;

  // set row memory
  row_t row_mem [SET_COUNT];

  logic             in_acc;
  logic             adv;
  logic             commit;
  byte_addr_t       addr_m;
  logic [IDX_W-1:0] in_set;
  logic [TAG_W-1:0] in_tag;

  row_t              row_cur;
  row_t              row_new;
  logic              any_hit;
  logic              any_inv;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  inv_way;
  logic [WAY_W-1:0]  lru_way;
  logic [WAY_W-1:0]  tgt_way;
  logic [RANK_W-1:0] age_limit;
  logic              age_all;

  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  row_t             mem_wd;

  // handshake: the output register parts the two sides, the lookup stage
  // moves on whenever the output register is free or being emptied
  assign adv           = !out_v_r || out_chan.ready;
  assign in_chan.ready = !clr_busy_r && (!s1_v_r || adv);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign commit        = s1_v_r && adv;

  assign out_chan.valid  = out_v_r;
  assign out_chan.is_hit = out_hit_r;

  // address split: drop bits above ADDR_BITS, then offset, index and tag
  assign addr_m = in_chan.byte_address & ADDR_MASK;
  assign in_set = IDX_W'((addr_m >> OFF_BITS) & SET_MASK);
  assign in_tag = TAG_W'(addr_m >> (OFF_BITS + IDX_BITS));

  // a row committed on the edge that read the same set comes from the
  // forward register instead of the stale memory word
  assign row_cur = fwd_v_r ? fwd_row_r : row_rd_r;

  // tag compare, first invalid way and oldest way of the set
  always_comb begin
    any_hit = 1'b0;
    hit_way = '0;
    any_inv = 1'b0;
    inv_way = '0;
    lru_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_cur[w].vld && (row_cur[w].tag == s1_tag_r)) begin
        any_hit = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!row_cur[w].vld) begin
        any_inv = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (row_cur[w].rank > row_cur[lru_way].rank) begin
        lru_way = WAY_W'(w);
      end
    end
  end

  // pick the way to promote and how far the others age
  always_comb begin
    if (any_hit) begin
      tgt_way   = hit_way;
      age_limit = row_cur[hit_way].rank;
      age_all   = 1'b0;
    end else if (any_inv) begin
      tgt_way   = inv_way;
      age_limit = '0;
      age_all   = 1'b1;
    end else begin
      tgt_way   = lru_way;
      age_limit = row_cur[lru_way].rank;
      age_all   = 1'b0;
    end
  end

  // updated set row
  always_comb begin
    row_new = row_cur;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == tgt_way) begin
        row_new[w].vld  = 1'b1;
        row_new[w].rank = '0;
        if (!any_hit) begin
          row_new[w].tag = s1_tag_r;
        end
      end else if (row_cur[w].vld && (age_all || (row_cur[w].rank < age_limit))) begin
        row_new[w].rank = row_cur[w].rank + RANK_W'(1);
      end
    end
  end

  // one write port: clearing pass after reset, then committed lookups
  always_comb begin
    if (clr_busy_r) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else begin
      mem_we = commit;
      mem_wa = s1_set_r;
      mem_wd = row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[mem_wa] <= mem_wd;
    end
    if (in_acc) begin
      row_rd_r <= row_mem[in_set];
    end
  end

  // clearing pass control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      if (clr_cnt_r == LAST_SET) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // lookup stage and forward register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r  <= 1'b1;
        fwd_v_r <= commit && (in_set == s1_set_r);
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_set_r  <= in_set;
      s1_tag_r  <= in_tag;
      fwd_row_r <= row_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit_r <= any_hit;
    end
  end

endmodule

@@ rtl/core/slru_checker.sv @@
module slru_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_is_hit
);

  // reset starts the clearing pass and empties the result register
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_ready))
    else $error("not idle after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_is_hit)))
    else $error("stalled result changed");

  // every accepted request is followed by out_valid high
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##2 out_valid)
    else $error("result missing after request");

  // no result without an earlier accepted request
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without request");

endmodule

bind set_assoc_lru_tag_lookup slru_checker u_slru_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_is_hit (out_chan.is_hit)
);

@@ test/slru_tb_pkg.sv @@
package slru_tb_pkg;
  import slru_pkg::*;

  localparam int unsigned SETS      = 128;
  localparam int unsigned LINE_B    = 16;
  localparam int unsigned NWAYS     = 2;
  localparam int unsigned OFF_W     = $clog2(LINE_B);
  localparam int unsigned SET_W     = $clog2(SETS);
  localparam int unsigned TAG_W     = IN_ADDR_W - OFF_W - SET_W;

  typedef logic [TAG_W-1:0] tag_t;

  // mirrors the tag directory and keeps the hit flags still owed by the block
  class hit_scoreboard;
    tag_t        tags   [SETS*NWAYS];
    bit          valids [SETS*NWAYS];
    int unsigned ranks  [SETS*NWAYS];
    bit          expected_hits[$];
    int unsigned errors;

    function new();
      foreach (valids[i]) begin
        valids[i] = 1'b0;
        ranks[i]  = 0;
        tags[i]   = '0;
      end
      errors = 0;
    endfunction

    // ages the younger valid ways of the set, then makes way the newest
    function void make_newest(int unsigned base, int unsigned way, int unsigned limit);
      for (int unsigned w = 0; w < NWAYS; w++) begin
        if (w != way && valids[base+w] && ranks[base+w] < limit)
          ranks[base+w]++;
      end
      ranks[base+way] = 0;
    endfunction

    function bit predict_hit(byte_addr_t addr);
      int unsigned base;
      int unsigned victim;
      int unsigned limit;
      tag_t        tag;
      bit          found_free;
      base       = addr[OFF_W +: SET_W] * NWAYS;
      tag        = addr[IN_ADDR_W-1 -: TAG_W];
      found_free = 1'b0;
      victim     = 0;
      for (int unsigned w = 0; w < NWAYS; w++) begin
        if (valids[base+w] && tags[base+w] == tag) begin
          make_newest(base, w, ranks[base+w]);
          return 1'b1;
        end
      end
      for (int unsigned w = 0; w < NWAYS; w++) begin
        if (!found_free && !valids[base+w]) begin
          found_free = 1'b1;
          victim     = w;
        end
      end
      if (found_free) begin
        limit = NWAYS;
      end else begin
        for (int unsigned w = 1; w < NWAYS; w++)
          if (ranks[base+w] > ranks[base+victim]) victim = w;
        limit = ranks[base+victim];
      end
      tags[base+victim]   = tag;
      valids[base+victim] = 1'b1;
      make_newest(base, victim, limit);
      return 1'b0;
    endfunction

    function void note_lookup(byte_addr_t addr);
      expected_hits = {expected_hits, predict_hit(addr)};
    endfunction

    function void check_hit(bit is_hit);
      bit want;
      if (expected_hits.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual is_hit=%0b", $time, is_hit);
      end else begin
        want = expected_hits.pop_front();
        if (want !== is_hit) begin
          errors++;
          $display("%0t: is_hit mismatch, expected %0b, actual %0b", $time, want, is_hit);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_hits.size();
    endfunction
  endclass

endpackage

@@ test/tb_top.sv @@
module tb_top;
  import slru_pkg::*;
  import slru_tb_pkg::*;

  localparam int unsigned RAND_ITEMS  = 1900;
  localparam int unsigned CALM_ITEMS  = 200;   // tail of the run with no idling
  localparam int unsigned DRAIN_WAIT  = 10;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  bit   quiet;       // no idling on either side while set
  int unsigned cycle_count;

  slru_addr_if addr_ch ();
  slru_hit_if  hit_ch ();

  hit_scoreboard sb = new();

  set_assoc_lru_tag_lookup dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (addr_ch),
    .out_chan (hit_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog, also covers the clearing pass after reset
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // every accepted lookup request gets its predicted hit flag
  always @(posedge clk) begin
    if (rst_n && addr_ch.valid && addr_ch.ready)
      sb.note_lookup(addr_ch.byte_address);
  end

  // every accepted result is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && hit_ch.valid && hit_ch.ready)
      sb.check_hit(hit_ch.is_hit);
  end

  // result side: ready with random stall bursts
  initial begin
    hit_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 9) == 0) begin
        hit_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      hit_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // hold one request until the block takes it
  task automatic send_lookup(input byte_addr_t addr);
    addr_ch.valid        <= 1'b1;
    addr_ch.byte_address <= addr;
    do @(posedge clk); while (!addr_ch.ready);
  endtask

  // sender gap with valid low
  task automatic idle_burst();
    addr_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 17)) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 7) == 0) idle_burst();
  endtask

  // hot sets and a small tag pool keep hits and evictions frequent
  logic [SET_W-1:0] hot_sets [8];
  tag_t             tag_pool [6];

  function automatic byte_addr_t pick_address();
    byte_addr_t a;
    logic [SET_W-1:0] s;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      a = $urandom();                                   // pure noise
    end else begin
      if (roll < 70) s = hot_sets[$urandom_range(0, 7)];
      else           s = SET_W'($urandom_range(0, SETS-1));
      a = {tag_pool[$urandom_range(0, 5)], s, OFF_W'($urandom())};
    end
    return a;
  endfunction

  byte_addr_t directed [20] = '{
    32'h0000_0000,  // cold miss, fills way 0 of set 0
    32'h0000_0000,  // hit
    32'h0000_000F,  // hit, same line, other byte
    32'h0000_0800,  // same set, new tag, fills the free way
    32'h0000_0000,  // hit, way 0 becomes newest
    32'h0000_1000,  // set full, evicts the older way
    32'h0000_0800,  // evicted tag misses again, evicts the other way
    32'h0000_1000,  // hit after eviction
    32'hFFFF_FFFF,  // top set, all-ones tag
    32'hFFFF_FFF0,  // hit
    32'hFFFF_F7FF,  // top set, second tag
    32'hFFFF_FFFF,  // hit
    32'h0000_07F0,  // top set, tag zero, eviction
    32'hFFFF_F7FF,  // lru victim check
    32'h8000_0000,
    32'h7FFF_FFFF,
    32'h5555_5555,
    32'hAAAA_AAAA,
    32'h5555_5555,
    32'hAAAA_AAAA
  };

  initial begin
    rst_n                <= 1'b0;
    quiet                 = 1'b0;
    cycle_count           = 0;
    addr_ch.valid        <= 1'b0;
    addr_ch.byte_address <= '0;
    foreach (hot_sets[i]) hot_sets[i] = SET_W'($urandom_range(0, SETS-1));
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 6; i++) tag_pool[i] = TAG_W'($urandom());

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, back to back with occasional gaps
    foreach (directed[i]) begin
      maybe_idle();
      send_lookup(directed[i]);
    end

    // random part: alternating stretches with and without idling
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      quiet = (n >= RAND_ITEMS - CALM_ITEMS) || ((n / 150) % 3 == 1);
      if (n == RAND_ITEMS / 2) begin
        // let the pipe run dry before carrying on
        addr_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      maybe_idle();
      send_lookup(pick_address());
    end
    addr_ch.valid <= 1'b0;

    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
